>>> design/pptb_pkg.sv
// Shared constants, codes and types of the per-peer token bucket queue.
package pptb_pkg;

   localparam int PEERS       = 8;
   localparam int QUEUE_DEPTH = 8;
   localparam int SLOTS       = (PEERS < 8) ? PEERS : 8;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int HEAD_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W      = $clog2(SLOTS * QUEUE_DEPTH);
   localparam int ENTRY_W     = 9;

   localparam logic [15:0] BURST_RESET  = 16'd3000;
   localparam logic [9:0]  REFILL_RESET = 10'd2;
   localparam logic [3:0]  LIMIT_RESET  = 4'd6;
   localparam logic [15:0] TOKEN_MILLI  = 16'd1000;

   localparam logic [1:0] OP_ENQUEUE    = 2'd0;
   localparam logic [1:0] OP_TICK       = 2'd1;
   localparam logic [1:0] OP_PEER_LEFT  = 2'd2;
   localparam logic [1:0] OP_DISCONNECT = 2'd3;

   localparam logic [2:0] STAT_QUEUED  = 3'd0;
   localparam logic [2:0] STAT_DROPPED = 3'd1;
   localparam logic [2:0] STAT_IGNORED = 3'd2;
   localparam logic [2:0] STAT_GRANTED = 3'd3;
   localparam logic [2:0] STAT_IDLE    = 3'd4;
   localparam logic [2:0] STAT_CLEARED = 3'd5;

   localparam logic [1:0] CSR_BURST  = 2'd0;
   localparam logic [1:0] CSR_REFILL = 2'd1;
   localparam logic [1:0] CSR_LIMIT  = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_VISIT,
      ST_WAIT,
      ST_TICK_END,
      ST_CLR_ALL
   } state_type;

   typedef struct packed {
      logic [31:0] last_time;
      logic [15:0] level;
   } bucket_entry_type;

   typedef struct packed {
      logic              visit;
      logic              clear;
      logic [SLOT_W-1:0] slot;
      logic [15:0]       clear_level;
   } bucket_cmd_type;

   typedef struct packed {
      logic valid;
      logic grant;
   } bucket_res_type;

   typedef struct packed {
      logic               push;
      logic               pop_rd;
      logic               pop_commit;
      logic               clear_one;
      logic               clear_all;
      logic [SLOT_W-1:0]  slot;
      logic [ENTRY_W-1:0] entry;
   } queue_cmd_type;

   typedef struct packed {
      logic nonempty;
      logic full;
   } queue_stat_type;

endpackage

>>> design/pptb_bucket.sv
// Token bucket memory with its refill, cap and spend pipeline.
module pptb_bucket (
   input  logic                     clock,
   input  logic                     reset,
   input  pptb_pkg::bucket_cmd_type bkt_cmd,
   input  logic [31:0]              now_ms,
   input  logic [15:0]              burst,
   input  logic [9:0]               refill,
   output pptb_pkg::bucket_res_type bkt_res
);

   pptb_pkg::bucket_entry_type bucket_mem [pptb_pkg::SLOTS];
   pptb_pkg::bucket_entry_type rd_ff;

   logic                        s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [pptb_pkg::SLOT_W-1:0] slot1_ff, slot2_ff, slot3_ff;
   logic [31:0]                 elapsed_ff;
   logic                        apply_b_ff, apply_c_ff;
   logic [15:0]                 level_b_ff, level_c_ff;
   logic [16:0]                 prod_ff;

   logic [41:0] prod;
   logic [16:0] prod_in;
   logic [17:0] sum;
   logic [15:0] capped;
   logic [15:0] level_upd;
   logic        grant;
   logic [15:0] level_in;

   always_comb begin
      prod    = 42'(refill) * 42'(elapsed_ff);
      prod_in = (prod[41:17] != '0) ? 17'h1FFFF : prod[16:0];
   end

   always_comb begin
      sum       = 18'(level_c_ff) + 18'(prod_ff);
      capped    = (sum > 18'(burst)) ? burst : sum[15:0];
      level_upd = apply_c_ff ? capped : level_c_ff;
      grant     = (level_upd >= pptb_pkg::TOKEN_MILLI);
      level_in  = grant ? (level_upd - pptb_pkg::TOKEN_MILLI) : level_upd;
   end

   assign bkt_res.valid = s3_valid_ff;
   assign bkt_res.grant = grant;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= bkt_cmd.visit;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      slot1_ff   <= bkt_cmd.slot;
      slot2_ff   <= slot1_ff;
      slot3_ff   <= slot2_ff;
      elapsed_ff <= now_ms - rd_ff.last_time;
      apply_b_ff <= (rd_ff.last_time != 32'd0) && (now_ms > rd_ff.last_time);
      level_b_ff <= rd_ff.level;
      prod_ff    <= prod_in;
      apply_c_ff <= apply_b_ff;
      level_c_ff <= level_b_ff;
   end

   always_ff @(posedge clock) begin
      if (bkt_cmd.visit) begin
         rd_ff <= bucket_mem[bkt_cmd.slot];
      end
      if (bkt_cmd.clear) begin
         bucket_mem[bkt_cmd.slot] <= '{last_time: 32'd0, level: bkt_cmd.clear_level};
      end else if (s3_valid_ff) begin
         bucket_mem[slot3_ff] <= '{last_time: now_ms, level: level_in};
      end
   end

endmodule

>>> design/pptb_queue.sv
// Per-peer request FIFOs: entry memory with head and count pointers.
module pptb_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  pptb_pkg::queue_cmd_type         q_cmd,
   input  logic [3:0]                      queue_limit,
   output pptb_pkg::queue_stat_type        q_stat,
   output logic [pptb_pkg::ENTRY_W-1:0]    rd_entry
);

   localparam int SUM_W = pptb_pkg::CNT_W + 1;
   localparam int HN_W  = pptb_pkg::HEAD_W + 1;
   localparam logic [pptb_pkg::ADDR_W-1:0] DEPTH_A = pptb_pkg::ADDR_W'(pptb_pkg::QUEUE_DEPTH);

   logic [pptb_pkg::ENTRY_W-1:0] store_mem [pptb_pkg::SLOTS * pptb_pkg::QUEUE_DEPTH];
   logic [pptb_pkg::ENTRY_W-1:0] rd_entry_ff;

   logic [pptb_pkg::HEAD_W-1:0] head_ff  [pptb_pkg::SLOTS];
   logic [pptb_pkg::CNT_W-1:0]  count_ff [pptb_pkg::SLOTS];

   logic [pptb_pkg::HEAD_W-1:0] head_sel;
   logic [pptb_pkg::CNT_W-1:0]  count_sel;
   logic [4:0]                  lim;
   logic [SUM_W-1:0]            tail_sum;
   logic [SUM_W-1:0]            tail_pos;
   logic [HN_W-1:0]             head_inc;
   logic [pptb_pkg::HEAD_W-1:0] head_in;
   logic [pptb_pkg::ADDR_W-1:0] base;
   logic [pptb_pkg::ADDR_W-1:0] push_addr;
   logic [pptb_pkg::ADDR_W-1:0] pop_addr;

   always_comb begin
      head_sel  = head_ff[q_cmd.slot];
      count_sel = count_ff[q_cmd.slot];
      lim       = ({1'b0, queue_limit} > 5'(pptb_pkg::QUEUE_DEPTH)) ?
                  5'(pptb_pkg::QUEUE_DEPTH) : {1'b0, queue_limit};
      tail_sum  = SUM_W'(head_sel) + SUM_W'(count_sel);
      tail_pos  = (tail_sum >= SUM_W'(pptb_pkg::QUEUE_DEPTH)) ?
                  (tail_sum - SUM_W'(pptb_pkg::QUEUE_DEPTH)) : tail_sum;
      head_inc  = HN_W'(head_sel) + HN_W'(1);
      head_in   = (head_inc == HN_W'(pptb_pkg::QUEUE_DEPTH)) ?
                  '0 : head_inc[pptb_pkg::HEAD_W-1:0];
      base      = pptb_pkg::ADDR_W'(q_cmd.slot) * DEPTH_A;
      push_addr = base + pptb_pkg::ADDR_W'(tail_pos);
      pop_addr  = base + pptb_pkg::ADDR_W'(head_sel);
   end

   assign q_stat.nonempty = (count_sel != '0);
   assign q_stat.full     = (5'(count_sel) >= lim);
   assign rd_entry        = rd_entry_ff;

   always_ff @(posedge clock) begin
      if (reset || q_cmd.clear_all) begin
         for (int i = 0; i < pptb_pkg::SLOTS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (q_cmd.clear_one) begin
         head_ff[q_cmd.slot]  <= '0;
         count_ff[q_cmd.slot] <= '0;
      end else if (q_cmd.push) begin
         count_ff[q_cmd.slot] <= count_sel + pptb_pkg::CNT_W'(1);
      end else if (q_cmd.pop_commit) begin
         head_ff[q_cmd.slot]  <= head_in;
         count_ff[q_cmd.slot] <= count_sel - pptb_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (q_cmd.push) begin
         store_mem[push_addr] <= q_cmd.entry;
      end
      if (q_cmd.pop_rd) begin
         rd_entry_ff <= store_mem[pop_addr];
      end
   end

endmodule

>>> design/per_peer_token_bucket_queue.sv
// Top level: command sequencer, configuration registers and result register.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  request  | start / busy       | req_opcode req_peer_slot req_item_index
//           |                    | req_item_dir req_now_ms
//  result   | rsp_valid strobe   | rsp_status rsp_out_slot rsp_out_index rsp_out_dir
//           |                    | rsp_last
//  config   | csr_we             | csr_index csr_wdata
//
//  Enqueue and peer left: result registered from the EXEC state, next item taken as it shows.
//  Tick: visits slots 1 to SLOTS-1 in order; an empty slot is passed over, a non-empty one goes
//  through bucket memory read, elapsed time, multiply, update and write back.
//  Disconnect: a sweep over every bucket memory slot, then one result.
//  Reset: a clearing pass over every bucket memory slot, busy held high.
//  Results are strobed for one cycle each; the receiver cannot stall.
module per_peer_token_bucket_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_peer_slot,
   input  logic [7:0]  req_item_index,
   input  logic        req_item_dir,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_out_slot,
   output logic [7:0]  rsp_out_index,
   output logic        rsp_out_dir,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int SW = pptb_pkg::SLOT_W;
   localparam logic [SW-1:0] SLOT_LAST = SW'(pptb_pkg::SLOTS - 1);

   pptb_pkg::state_type state_ff, state_in;

   logic [15:0] burst_ff;
   logic [9:0]  refill_ff;
   logic [3:0]  limit_ff;

   logic [1:0]  op_ff;
   logic [2:0]  slot_ff;
   logic [7:0]  index_ff;
   logic        dir_ff;
   logic [31:0] now_ff;

   logic [SW-1:0] visit_ff, visit_in;
   logic [SW-1:0] clr_ff, clr_in;

   logic       pend_valid_ff, pend_valid_in;
   logic [2:0] pend_slot_ff, pend_slot_in;
   logic [7:0] pend_index_ff, pend_index_in;
   logic       pend_dir_ff, pend_dir_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [2:0] rsp_slot_ff, rsp_slot_in;
   logic [7:0] rsp_index_ff, rsp_index_in;
   logic       rsp_dir_ff, rsp_dir_in;
   logic       rsp_last_ff, rsp_last_in;

   pptb_pkg::bucket_cmd_type bkt_cmd;
   pptb_pkg::bucket_res_type bkt_res;
   pptb_pkg::queue_cmd_type  q_cmd;
   pptb_pkg::queue_stat_type q_stat;
   logic [pptb_pkg::ENTRY_W-1:0] rd_entry;

   logic          accept;
   logic          slot_ok;
   logic [SW-1:0] slot_idx;
   logic          visit_last;
   logic          clr_last;

   assign busy       = (state_ff != pptb_pkg::ST_IDLE);
   assign accept     = start && !busy;
   assign slot_ok    = ({1'b0, slot_ff} < 4'(pptb_pkg::SLOTS));
   assign slot_idx   = slot_ff[SW-1:0];
   assign visit_last = (visit_ff == SLOT_LAST);
   assign clr_last   = (clr_ff == SLOT_LAST);

   pptb_bucket u_bucket (
      .clock   (clock),
      .reset   (reset),
      .bkt_cmd (bkt_cmd),
      .now_ms  (now_ff),
      .burst   (burst_ff),
      .refill  (refill_ff),
      .bkt_res (bkt_res)
   );

   pptb_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .q_cmd       (q_cmd),
      .queue_limit (limit_ff),
      .q_stat      (q_stat),
      .rd_entry    (rd_entry)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pptb_pkg::ST_INIT: begin
            if (clr_last) state_in = pptb_pkg::ST_IDLE;
         end
         pptb_pkg::ST_IDLE: begin
            if (accept) state_in = pptb_pkg::ST_EXEC;
         end
         pptb_pkg::ST_EXEC: begin
            unique case (op_ff)
               pptb_pkg::OP_TICK:       state_in = pptb_pkg::ST_VISIT;
               pptb_pkg::OP_DISCONNECT: state_in = pptb_pkg::ST_CLR_ALL;
               default:                 state_in = pptb_pkg::ST_IDLE;
            endcase
         end
         pptb_pkg::ST_VISIT: begin
            if (q_stat.nonempty)  state_in = pptb_pkg::ST_WAIT;
            else if (visit_last)  state_in = pptb_pkg::ST_TICK_END;
         end
         pptb_pkg::ST_WAIT: begin
            if (bkt_res.valid) begin
               state_in = visit_last ? pptb_pkg::ST_TICK_END : pptb_pkg::ST_VISIT;
            end
         end
         pptb_pkg::ST_TICK_END: state_in = pptb_pkg::ST_IDLE;
         pptb_pkg::ST_CLR_ALL: begin
            if (clr_last) state_in = pptb_pkg::ST_IDLE;
         end
         default: state_in = pptb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      bkt_cmd       = '0;
      q_cmd         = '0;
      q_cmd.entry   = {dir_ff, index_ff};
      visit_in      = visit_ff;
      clr_in        = clr_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_index_in = pend_index_ff;
      pend_dir_in   = pend_dir_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         pptb_pkg::ST_INIT: begin
            bkt_cmd.clear       = 1'b1;
            bkt_cmd.slot        = clr_ff;
            bkt_cmd.clear_level = pptb_pkg::BURST_RESET;
            clr_in              = clr_last ? '0 : clr_ff + SW'(1);
         end
         pptb_pkg::ST_IDLE: begin
         end
         pptb_pkg::ST_EXEC: begin
            clr_in        = '0;
            visit_in      = SW'(1);
            pend_valid_in = 1'b0;
            q_cmd.slot    = slot_idx;
            rsp_slot_in   = slot_ff;
            rsp_index_in  = 8'd0;
            rsp_dir_in    = 1'b0;
            rsp_last_in   = 1'b1;
            unique case (op_ff)
               pptb_pkg::OP_ENQUEUE: begin
                  rsp_valid_in = 1'b1;
                  if (!slot_ok || slot_ff == 3'd0) begin
                     rsp_status_in = pptb_pkg::STAT_IGNORED;
                  end else if (q_stat.full) begin
                     rsp_status_in = pptb_pkg::STAT_DROPPED;
                  end else begin
                     q_cmd.push    = 1'b1;
                     rsp_status_in = pptb_pkg::STAT_QUEUED;
                  end
               end
               pptb_pkg::OP_PEER_LEFT: begin
                  rsp_valid_in = 1'b1;
                  if (slot_ok) begin
                     q_cmd.clear_one     = 1'b1;
                     bkt_cmd.clear       = 1'b1;
                     bkt_cmd.slot        = slot_idx;
                     bkt_cmd.clear_level = burst_ff;
                     rsp_status_in       = pptb_pkg::STAT_CLEARED;
                  end else begin
                     rsp_status_in = pptb_pkg::STAT_IGNORED;
                  end
               end
               pptb_pkg::OP_DISCONNECT: begin
                  q_cmd.clear_all = 1'b1;
               end
               default: begin
               end
            endcase
         end
         pptb_pkg::ST_VISIT: begin
            q_cmd.slot = visit_ff;
            if (q_stat.nonempty) begin
               bkt_cmd.visit = 1'b1;
               bkt_cmd.slot  = visit_ff;
               q_cmd.pop_rd  = 1'b1;
            end else if (!visit_last) begin
               visit_in = visit_ff + SW'(1);
            end
         end
         pptb_pkg::ST_WAIT: begin
            q_cmd.slot = visit_ff;
            if (bkt_res.valid) begin
               if (!visit_last) visit_in = visit_ff + SW'(1);
               if (bkt_res.grant) begin
                  q_cmd.pop_commit = 1'b1;
                  // release the previous grant, hold this one until the next is known
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pptb_pkg::STAT_GRANTED;
                     rsp_slot_in   = pend_slot_ff;
                     rsp_index_in  = pend_index_ff;
                     rsp_dir_in    = pend_dir_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = 3'(visit_ff);
                  pend_index_in = rd_entry[7:0];
                  pend_dir_in   = rd_entry[8];
               end
            end
         end
         pptb_pkg::ST_TICK_END: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            if (pend_valid_ff) begin
               rsp_status_in = pptb_pkg::STAT_GRANTED;
               rsp_slot_in   = pend_slot_ff;
               rsp_index_in  = pend_index_ff;
               rsp_dir_in    = pend_dir_ff;
            end else begin
               rsp_status_in = pptb_pkg::STAT_IDLE;
               rsp_slot_in   = 3'd0;
               rsp_index_in  = 8'd0;
               rsp_dir_in    = 1'b0;
            end
         end
         pptb_pkg::ST_CLR_ALL: begin
            bkt_cmd.clear       = 1'b1;
            bkt_cmd.slot        = clr_ff;
            bkt_cmd.clear_level = burst_ff;
            clr_in              = clr_last ? '0 : clr_ff + SW'(1);
            if (clr_last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pptb_pkg::STAT_CLEARED;
               rsp_slot_in   = 3'd0;
               rsp_index_in  = 8'd0;
               rsp_dir_in    = 1'b0;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pptb_pkg::ST_INIT;
         visit_ff      <= SW'(1);
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         visit_ff      <= visit_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff  <= pptb_pkg::BURST_RESET;
         refill_ff <= pptb_pkg::REFILL_RESET;
         limit_ff  <= pptb_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pptb_pkg::CSR_BURST:  burst_ff  <= csr_wdata;
            pptb_pkg::CSR_REFILL: refill_ff <= csr_wdata[9:0];
            pptb_pkg::CSR_LIMIT:  limit_ff  <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         slot_ff  <= req_peer_slot;
         index_ff <= req_item_index;
         dir_ff   <= req_item_dir;
         now_ff   <= req_now_ms;
      end
      pend_slot_ff  <= pend_slot_in;
      pend_index_ff <= pend_index_in;
      pend_dir_ff   <= pend_dir_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_slot  = rsp_slot_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_dir   = rsp_dir_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == !busy))
      else $error("final result and busy disagree");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == pptb_pkg::OP_ENQUEUE ||
                          req_opcode == pptb_pkg::OP_PEER_LEFT))
      |=> ##1 (rsp_valid && rsp_last))
      else $error("enqueue or peer left gave no final result");

   a_grant_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == pptb_pkg::STAT_GRANTED) |-> (rsp_out_slot != 3'd0))
      else $error("grant issued for slot zero");
`endif

endmodule

>>> test/grant_check_pkg.sv
// Scoreboard for the per-peer token bucket queue: bucket and queue prediction plus result checks.
package grant_check_pkg;

   import pptb_pkg::*;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] slot;
      logic [7:0] index;
      logic       dir;
      logic       last;
   } outcome_type;

   class grant_scoreboard;
      logic [15:0] burst;
      logic [9:0]  refill;
      logic [3:0]  limit;
      logic [15:0] level [SLOTS];
      logic [31:0] stamp [SLOTS];
      logic [8:0]  store [SLOTS * QUEUE_DEPTH];
      int unsigned head [SLOTS];
      int unsigned fill [SLOTS];
      outcome_type awaited_outcomes [$];
      int          errors;

      function new();
         burst  = BURST_RESET;
         refill = REFILL_RESET;
         limit  = LIMIT_RESET;
         errors = 0;
         for (int s = 0; s < SLOTS; s++) empty_slot(s);
      endfunction

      function void empty_slot(int unsigned s);
         level[s] = burst;
         stamp[s] = '0;
         head[s]  = 0;
         fill[s]  = 0;
      endfunction

      function outcome_type make(logic [2:0] status, logic [2:0] slot, logic [7:0] index,
                                 logic dir);
         outcome_type o;
         o.status = status;
         o.slot   = slot;
         o.index  = index;
         o.dir    = dir;
         o.last   = 1'b0;
         return o;
      endfunction

      function void apply_register(logic [1:0] index, logic [15:0] data);
         case (index)
            CSR_BURST:  burst  = data;
            CSR_REFILL: refill = data[9:0];
            CSR_LIMIT:  limit  = data[3:0];
            default: ;
         endcase
      endfunction

      function void serve_request(logic [1:0] op, logic [2:0] slot, logic [7:0] index,
                                  logic dir, logic [31:0] now);
         outcome_type batch [$];
         outcome_type o;
         int unsigned lim;
         int unsigned pos;
         logic [63:0] sum;
         logic [8:0]  e;
         case (op)
            OP_ENQUEUE: begin
               lim = (limit < QUEUE_DEPTH) ? limit : QUEUE_DEPTH;
               if (slot < 1 || slot >= SLOTS) begin
                  batch.insert(batch.size(), make(STAT_IGNORED, slot, 8'd0, 1'b0));
               end else if (fill[slot] >= lim) begin
                  batch.insert(batch.size(), make(STAT_DROPPED, slot, 8'd0, 1'b0));
               end else begin
                  pos = (head[slot] + fill[slot]) % QUEUE_DEPTH;
                  store[slot * QUEUE_DEPTH + pos] = {dir, index};
                  fill[slot]++;
                  batch.insert(batch.size(), make(STAT_QUEUED, slot, 8'd0, 1'b0));
               end
            end
            OP_TICK: begin
               for (int s = 1; s < SLOTS; s++) begin
                  if (fill[s] != 0) begin
                     if (stamp[s] != 0 && now > stamp[s]) begin
                        sum = 64'(level[s]) + 64'(refill) * 64'(now - stamp[s]);
                        if (sum > 64'(burst)) sum = 64'(burst);
                        level[s] = sum[15:0];
                     end
                     stamp[s] = now;
                     if (level[s] >= TOKEN_MILLI) begin
                        level[s] = level[s] - TOKEN_MILLI;
                        e = store[s * QUEUE_DEPTH + head[s]];
                        head[s] = (head[s] + 1) % QUEUE_DEPTH;
                        fill[s]--;
                        batch.insert(batch.size(), make(STAT_GRANTED, 3'(s), e[7:0], e[8]));
                     end
                  end
               end
               if (batch.size() == 0) begin
                  batch.insert(batch.size(), make(STAT_IDLE, 3'd0, 8'd0, 1'b0));
               end
            end
            OP_PEER_LEFT: begin
               if (slot >= SLOTS) begin
                  batch.insert(batch.size(), make(STAT_IGNORED, slot, 8'd0, 1'b0));
               end else begin
                  empty_slot(slot);
                  batch.insert(batch.size(), make(STAT_CLEARED, slot, 8'd0, 1'b0));
               end
            end
            default: begin
               for (int s = 0; s < SLOTS; s++) empty_slot(s);
               batch.insert(batch.size(), make(STAT_CLEARED, 3'd0, 8'd0, 1'b0));
            end
         endcase
         o = batch[batch.size() - 1];
         o.last = 1'b1;
         batch[batch.size() - 1] = o;
         foreach (batch[i]) awaited_outcomes.insert(awaited_outcomes.size(), batch[i]);
      endfunction

      function void compare_field(string label, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", label, want, got);
            errors++;
         end
      endfunction

      function void check_outcome(outcome_type got);
         outcome_type want;
         if (awaited_outcomes.size() == 0) begin
            $error("unexpected result: status %0d slot %0d", got.status, got.slot);
            errors++;
            return;
         end
         want = awaited_outcomes[0];
         awaited_outcomes.delete(0);
         compare_field("status", want.status, got.status);
         compare_field("out_slot", want.slot, got.slot);
         compare_field("out_index", want.index, got.index);
         compare_field("out_dir", want.dir, got.dir);
         compare_field("last", want.last, got.last);
      endfunction

      function int outstanding();
         return awaited_outcomes.size();
      endfunction
   endclass

endpackage

>>> test/testbench.sv
// Top-level testbench driving the per-peer token bucket queue and checking every result.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pptb_pkg::*;
   import grant_check_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = OP_ENQUEUE;
   logic [2:0]  req_peer_slot = '0;
   logic [7:0]  req_item_index = '0;
   logic        req_item_dir = 1'b0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_out_slot;
   logic [7:0]  rsp_out_index;
   logic        rsp_out_dir;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_BURST;
   logic [15:0] csr_wdata = '0;

   grant_scoreboard board = new();
   bit              idling_on = 1'b1;
   logic [31:0]     wall_ms = 32'd1;
   int              quiet_cycles = 0;

   per_peer_token_bucket_queue dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_peer_slot  (req_peer_slot),
      .req_item_index (req_item_index),
      .req_item_dir   (req_item_dir),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_out_slot   (rsp_out_slot),
      .rsp_out_index  (rsp_out_index),
      .rsp_out_dir    (rsp_out_dir),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) board.apply_register(csr_index, csr_wdata);
         if (start && !busy) begin
            board.serve_request(req_opcode, req_peer_slot, req_item_index, req_item_dir,
                                req_now_ms);
         end
         if (rsp_valid) begin
            board.check_outcome({rsp_status, rsp_out_slot, rsp_out_index, rsp_out_dir,
                                 rsp_last});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == 1000) begin
         $error("no handshake for %0d cycles", quiet_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [2:0] slot,
                            input logic [7:0] index, input logic dir, input logic [31:0] now);
      if (idling_on && $urandom_range(0, 99) < 37) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 34)) @(posedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_peer_slot  <= slot;
      req_item_index <= index;
      req_item_dir   <= dir;
      req_now_ms     <= now;
      do @(posedge clock); while (busy);
   endtask

   task automatic program_register(input logic [1:0] index, input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // hold the sender until every awaited result is in and the block is idle
   task automatic settle();
      start <= 1'b0;
      do @(negedge clock); while (board.outstanding() != 0);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic run_directed();
      send_item(OP_TICK, 3'd0, 8'd0, 1'b0, 32'd0);
      send_item(OP_ENQUEUE, 3'd0, 8'hFF, 1'b1, 32'd0);
      send_item(OP_ENQUEUE, 3'd7, 8'hFF, 1'b1, 32'hFFFF_FFFF);
      for (int n = 0; n < 7; n++) send_item(OP_ENQUEUE, 3'd1, 8'(n * 37), 1'(n), 32'd0);
      send_item(OP_TICK, 3'd0, 8'd0, 1'b0, 32'd100);
      send_item(OP_TICK, 3'd0, 8'd0, 1'b0, 32'd50);
      send_item(OP_TICK, 3'd0, 8'd0, 1'b0, 32'd60);
      send_item(OP_TICK, 3'd0, 8'd0, 1'b0, 32'd70);
      send_item(OP_TICK, 3'd0, 8'd0, 1'b0, 32'hFFFF_FFFF);
      send_item(OP_PEER_LEFT, 3'd0, 8'd0, 1'b0, 32'd0);
      send_item(OP_PEER_LEFT, 3'd1, 8'd0, 1'b0, 32'd0);
      for (int s = 1; s < 8; s++) send_item(OP_ENQUEUE, 3'(s), 8'(s * 36 + 3), 1'(s), 32'd0);
      send_item(OP_TICK, 3'd0, 8'd0, 1'b0, 32'h8000_0000);
      send_item(OP_ENQUEUE, 3'd4, 8'h5A, 1'b0, 32'd0);
      send_item(OP_DISCONNECT, 3'd0, 8'd0, 1'b0, 32'd0);
   endtask

   task automatic run_phase(input int unsigned items);
      int unsigned pick;
      logic [1:0]  op;
      logic [31:0] now;
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(0, 99);
         now  = $urandom;
         if (pick < 48) begin
            op = OP_ENQUEUE;
         end else if (pick < 88) begin
            op   = OP_TICK;
            pick = $urandom_range(0, 99);
            if (pick < 78) wall_ms = wall_ms + $urandom_range(0, 2500);
            else if (pick < 86) wall_ms = wall_ms - $urandom_range(0, 3000);
            else if (pick < 89) wall_ms = '0;
            else if (pick < 94) wall_ms = $urandom;
            now = wall_ms;
         end else if (pick < 96) begin
            op = OP_PEER_LEFT;
         end else begin
            op = OP_DISCONNECT;
         end
         send_item(op, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), now);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (busy);

      run_directed();
      settle();

      program_register(CSR_BURST, 16'hFFFF);
      program_register(CSR_REFILL, 16'd1000);
      program_register(CSR_LIMIT, 16'd8);
      run_phase(60);
      settle();

      program_register(CSR_BURST, 16'd1000);
      program_register(CSR_REFILL, 16'd0);
      program_register(CSR_LIMIT, 16'd1);
      run_phase(40);
      settle();

      idling_on = 1'b0;
      program_register(CSR_BURST, 16'd4500);
      program_register(CSR_REFILL, 16'd37);
      program_register(CSR_LIMIT, 16'd15);
      run_phase(60);
      settle();
      idling_on = 1'b1;

      program_register(CSR_BURST, 16'd2000);
      program_register(CSR_LIMIT, 16'd0);
      run_phase(20);
      settle();

      repeat (2) begin
         program_register(CSR_BURST, 16'($urandom_range(1000, 65535)));
         program_register(CSR_REFILL, {6'($urandom), 10'($urandom_range(0, 1000))});
         program_register(CSR_LIMIT, {12'($urandom), 4'($urandom_range(0, 15))});
         run_phase(40);
         settle();
      end

      repeat (40) @(posedge clock);
      @(negedge clock);
      if (board.outstanding() != 0) begin
         $error("%0d results never arrived", board.outstanding());
      end
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
